>>> design/gram_pkg.sv
// ----------------------------------------------------------------------------
// gram_pkg: shared constants and types for the Gram matrix block
// Sizes, widths, size register indices, the sequencer state type and the row controls.
// ----------------------------------------------------------------------------
package gram_pkg;
	localparam int MaxRowsDef = 8;
	localparam int MaxColsDef = 8;
	localparam int ElemW      = 16;
	localparam int ProdW      = 35;
	localparam int IdxW       = 3;
	localparam int CfgW       = 4;

	localparam logic [0:0] REG_ROWS = 1'b0;
	localparam logic [0:0] REG_COLS = 1'b1;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_ROW,
		ST_MAC,
		ST_OUT
	} state_t;

	// controls from the sequencer to the cell row
	typedef struct packed {
		logic load;   // shift a new element into the row
		logic rot;    // rotate the row by one cell
	} row_ctrl_t;
endpackage

>>> design/gram_cell.sv
// ----------------------------------------------------------------------------
// gram_cell: one storage cell of the element row
// Takes its neighbor's element on a shift or a rotate and holds it otherwise.
// ----------------------------------------------------------------------------
module gram_cell (
	input  logic                            clk,
	input  gram_pkg::row_ctrl_t             ctrl,
	input  logic signed [gram_pkg::ElemW-1:0] prev,
	output logic signed [gram_pkg::ElemW-1:0] elem
);
	logic signed [gram_pkg::ElemW-1:0] elem_q;

	// take neighbor on any move
	always_ff @(posedge clk) begin
		if (ctrl.load || ctrl.rot) begin
			elem_q <= prev;
		end
	end

	assign elem = elem_q;
endmodule

>>> design/gram_matrix_a_times_a_transpose.sv
// ----------------------------------------------------------------------------
// gram_matrix_a_times_a_transpose: A times A-transpose over a row of cells
// Elements go to a store; row i is copied into a rotating chain of cells
// and one shared MAC pairs the chain tap with row j read from the store.
// ----------------------------------------------------------------------------
// Sequence: after the completing beat, row i is first copied into the chain;
//   then for each row j the MAC accumulates the chain tap times row j of the
//   store, and the finished sum is registered as one output beat.
// Throughput: one beat per cycle while loading; input stalls during compute.
// Reset: arst_n clears the sequencer, counters and size registers (8 x 8).
// The element store holds no reset; unwritten elements read as anything.
module gram_matrix_a_times_a_transpose #(
	parameter int MAX_ROWS = gram_pkg::MaxRowsDef,
	parameter int MAX_COLS = gram_pkg::MaxColsDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [gram_pkg::CfgW-1:0] cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // element_value[15:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,   // product_value[34:0], out_row[37:35], out_col[40:38]
	output logic        m_axis_tlast    // last_entry
);
	localparam int Depth = MAX_ROWS * MAX_COLS;
	localparam int CntW  = $clog2(Depth + 1);
	localparam int AdW   = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int RW    = $clog2(MAX_ROWS + 1);
	localparam int CW    = $clog2(MAX_COLS + 1);
	localparam int TapW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int MulW  = 2 * gram_pkg::ElemW;

	// size registers
	logic [gram_pkg::CfgW-1:0] rows_q, cols_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= gram_pkg::CfgW'(8);
			cols_q <= gram_pkg::CfgW'(8);
		end else if (cfg_we) begin
			if (cfg_index == gram_pkg::REG_ROWS) rows_q <= cfg_data;
			else cols_q <= cfg_data;
		end
	end

	// clamped sizes
	logic [RW-1:0] nr;
	logic [CW-1:0] nc;
	logic [CntW-1:0] total;
	always_comb begin
		if (rows_q == '0) nr = RW'(1);
		else if (32'(rows_q) > MAX_ROWS) nr = RW'(MAX_ROWS);
		else nr = RW'(rows_q);
		if (cols_q == '0) nc = CW'(1);
		else if (32'(cols_q) > MAX_COLS) nc = CW'(MAX_COLS);
		else nc = CW'(cols_q);
		total = CntW'(nr) * CntW'(nc);
	end

	// sequencer
	gram_pkg::state_t state_q, state_d;
	logic [CntW-1:0] cnt_q;
	logic [RW-1:0] i_q, j_q;
	logic [CW-1:0] k_q;
	logic s_acc;
	logic out_ok;
	logic emit;
	logic k_last;
	logic last_entry;
	logic row_s1, mac_s1, first_s1;

	assign s_axis_tready = (state_q == gram_pkg::ST_LOAD);
	assign s_acc = s_axis_tvalid && s_axis_tready;
	assign out_ok = !m_axis_tvalid || m_axis_tready;
	// the sum is complete once the last MAC cycle has left the pipe
	assign emit = (state_q == gram_pkg::ST_OUT) && out_ok && !mac_s1;
	assign k_last = (k_q == nc - CW'(1));
	assign last_entry = (i_q == nr - RW'(1)) && (j_q == nr - RW'(1));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			gram_pkg::ST_LOAD:
				if (s_acc && (cnt_q + CntW'(1) >= total)) state_d = gram_pkg::ST_ROW;
			gram_pkg::ST_ROW:
				if (k_last) state_d = gram_pkg::ST_MAC;
			gram_pkg::ST_MAC:
				if (k_last) state_d = gram_pkg::ST_OUT;
			gram_pkg::ST_OUT:
				if (emit) begin
					if (last_entry) state_d = gram_pkg::ST_LOAD;
					else if (j_q == nr - RW'(1)) state_d = gram_pkg::ST_ROW;
					else state_d = gram_pkg::ST_MAC;
				end
			default: state_d = gram_pkg::ST_LOAD;
		endcase
	end

	// store address: row i while filling the chain, row j while accumulating
	logic [RW-1:0] row_sel;
	logic [CntW-1:0] rd_ad;
	always_comb begin
		row_sel = (state_q == gram_pkg::ST_ROW) ? i_q : j_q;
		rd_ad = CntW'(row_sel) * CntW'(nc) + CntW'(k_q);
	end

	// element store, one write and one registered read per cycle
	logic signed [gram_pkg::ElemW-1:0] store_mem [Depth];
	logic signed [gram_pkg::ElemW-1:0] rd_s1;
	always_ff @(posedge clk) begin
		if (s_acc && (cnt_q < CntW'(Depth))) store_mem[cnt_q[AdW-1:0]] <= s_axis_tdata;
		rd_s1 <= store_mem[rd_ad[AdW-1:0]];
	end

	// row chain: loads row i, then rotates once per MAC beat of each entry
	gram_pkg::row_ctrl_t ctrl;
	logic signed [gram_pkg::ElemW-1:0] cell_e [MAX_COLS];
	logic signed [gram_pkg::ElemW-1:0] tap_e, head_e;
	logic [TapW-1:0] tap_idx;
	always_comb begin
		ctrl.load = row_s1;
		ctrl.rot  = mac_s1;
		tap_idx = TapW'(nc - CW'(1));
		tap_e = cell_e[tap_idx];
		head_e = row_s1 ? rd_s1 : tap_e;
	end

	for (genvar g = 0; g < MAX_COLS; g++) begin : g_row
		logic signed [gram_pkg::ElemW-1:0] prev;
		if (g == 0) begin : g_h
			assign prev = head_e;
		end else begin : g_t
			assign prev = cell_e[g-1];
		end
		gram_cell u_cell (.clk(clk), .ctrl(ctrl), .prev(prev), .elem(cell_e[g]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gram_pkg::ST_LOAD;
			cnt_q <= '0;
			i_q <= '0; j_q <= '0; k_q <= '0;
			row_s1 <= 1'b0; mac_s1 <= 1'b0; first_s1 <= 1'b0;
			m_axis_tvalid <= 1'b0;
		end else begin
			state_q <= state_d;
			row_s1 <= (state_q == gram_pkg::ST_ROW);
			mac_s1 <= (state_q == gram_pkg::ST_MAC);
			first_s1 <= (state_q == gram_pkg::ST_MAC) && (k_q == '0);
			m_axis_tvalid <= emit || (m_axis_tvalid && !m_axis_tready);
			if (s_acc) begin
				if (cnt_q + CntW'(1) >= total) begin
					cnt_q <= '0;
					i_q <= '0; j_q <= '0; k_q <= '0;
				end else cnt_q <= cnt_q + CntW'(1);
			end
			if (state_q == gram_pkg::ST_ROW || state_q == gram_pkg::ST_MAC) begin
				k_q <= k_last ? '0 : k_q + CW'(1);
			end
			if (emit) begin
				if (j_q == nr - RW'(1)) begin
					j_q <= '0; i_q <= i_q + RW'(1);
				end else j_q <= j_q + RW'(1);
			end
		end
	end

	// multiply the chain tap by the store word and accumulate
	logic signed [MulW-1:0] prod;
	logic signed [gram_pkg::ProdW-1:0] prod_ext, acc_q;
	always_comb begin
		prod = tap_e * rd_s1;
		prod_ext = {{(gram_pkg::ProdW - MulW){prod[MulW-1]}}, prod};
	end

	always_ff @(posedge clk) begin
		if (mac_s1) begin
			if (first_s1) acc_q <= prod_ext;
			else acc_q <= acc_q + prod_ext;
		end
		if (emit) begin
			m_axis_tdata <= {7'b0, gram_pkg::IdxW'(j_q), gram_pkg::IdxW'(i_q), acc_q};
			m_axis_tlast <= last_entry;
		end
	end

	// checks
	a_ready_load: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> state_q == gram_pkg::ST_LOAD) else $error("ready outside load");
	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("result dropped");
	a_k_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == gram_pkg::ST_ROW || state_q == gram_pkg::ST_MAC) |-> k_q < nc)
		else $error("k out of range");
	a_ctrl_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctrl.load && ctrl.rot)) else $error("load and rotate together");
endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the Gram matrix block
// Streams matrix elements under several size settings, predicts every entry
// of A times A-transpose and checks each output beat in order.
// ----------------------------------------------------------------------------
module tb;
	localparam int WatchLimit = 40000;

	typedef struct packed {
		logic signed [34:0] prod;
		logic [2:0]         row;
		logic [2:0]         col;
		logic               last;
	} gram_entry_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [0:0]  cfg_index;
	logic [3:0]  cfg_data;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [47:0] m_axis_tdata;
	logic        m_axis_tlast;

	gram_matrix_a_times_a_transpose dut (.*);

	// predictor state
	logic [3:0]         rows_reg, cols_reg;
	logic signed [15:0] elem_mem [64];
	int                 elem_count;

	logic [15:0]  element_queue [$];
	gram_entry_t  entry_queue [$];
	int           mismatch_count;
	int           idle_cycles;
	bit           timed_out;
	int           in_wait, out_wait;
	bit           s_hs_q, m_hs_q;

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	function automatic int clamp8(logic [3:0] v);
		if (v == 4'd0) return 1;
		if (v > 4'd8) return 8;
		return int'(v);
	endfunction

	// store one element; on the completing one queue the whole Gram matrix
	task automatic predict_gram(logic [15:0] e);
		int nr, nc;
		logic signed [34:0] acc;
		gram_entry_t ent;
		nr = clamp8(rows_reg);
		nc = clamp8(cols_reg);
		if (elem_count < 64) elem_mem[elem_count] = e;
		elem_count++;
		if (elem_count >= nr * nc) begin
			elem_count = 0;
			for (int i = 0; i < nr; i++)
				for (int j = 0; j < nr; j++) begin
					acc = '0;
					for (int k = 0; k < nc; k++)
						acc += 35'(elem_mem[i*nc+k]) * 35'(elem_mem[j*nc+k]);
					ent.prod = acc;
					ent.row  = 3'(i);
					ent.col  = 3'(j);
					ent.last = (i == nr-1) && (j == nr-1);
					entry_queue.push_back(ent);
				end
		end
	endtask

	// driver: pending elements go out with random gaps
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			in_wait       <= 0;
		end else if (s_axis_tvalid && !s_hs_q) begin
			// hold beat
		end else if (in_wait > 0) begin
			s_axis_tvalid <= 1'b0;
			in_wait       <= in_wait - 1;
		end else if (element_queue.size() > 0) begin
			s_axis_tvalid <= 1'b1;
			s_axis_tdata  <= element_queue.pop_front();
			in_wait       <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : 0;
		end else begin
			s_axis_tvalid <= 1'b0;
		end
	end

	// handshakes seen at the rising edge; input acceptance feeds the predictor
	always @(posedge clk) begin
		s_hs_q <= arst_n && s_axis_tvalid && s_axis_tready;
		m_hs_q <= arst_n && m_axis_tvalid && m_axis_tready;
		if (arst_n && s_axis_tvalid && s_axis_tready) predict_gram(s_axis_tdata);
	end

	// ready stalls drawn per output beat
	always @(negedge clk or negedge arst_n) begin
		int w;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			out_wait      <= 0;
		end else if (m_hs_q) begin
			w = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : 0;
			out_wait      <= w;
			m_axis_tready <= (w == 0);
		end else if (out_wait > 0) begin
			out_wait      <= out_wait - 1;
			m_axis_tready <= (out_wait == 1);
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// monitor: compare each output beat with the oldest expected entry
	always @(posedge clk) begin
		gram_entry_t exp_e;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (entry_queue.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected beat: data=%h last=%b", m_axis_tdata, m_axis_tlast);
			end else begin
				exp_e = entry_queue.pop_front();
				if (m_axis_tdata[34:0] !== exp_e.prod || m_axis_tdata[37:35] !== exp_e.row ||
				    m_axis_tdata[40:38] !== exp_e.col || m_axis_tlast !== exp_e.last) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display({"mismatch: exp prod=%0d r=%0d c=%0d l=%b, ",
							"got prod=%0d r=%0d c=%0d l=%b"},
							exp_e.prod, exp_e.row, exp_e.col, exp_e.last,
							$signed(m_axis_tdata[34:0]), m_axis_tdata[37:35],
							m_axis_tdata[40:38], m_axis_tlast);
				end
			end
		end
	end

	// watchdog on cycles with no accepted beat
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	task automatic write_size(logic [0:0] idx, logic [3:0] val);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		@(negedge clk);
		cfg_we = 1'b0;
		if (idx == gram_pkg::REG_ROWS) rows_reg = val; else cols_reg = val;
	endtask

	// wait until every queued element is sent and every entry has arrived
	task automatic drain;
		while (element_queue.size() > 0 || s_axis_tvalid || entry_queue.size() > 0) begin
			@(posedge clk);
			if (idle_cycles > WatchLimit) begin
				timed_out = 1'b1;
				return;
			end
		end
		repeat (20) @(posedge clk);
	endtask

	// fill whole matrices at the current size with random content or extreme values
	task automatic queue_matrices(int count, bit extremes);
		int n;
		n = clamp8(rows_reg) * clamp8(cols_reg);
		for (int m = 0; m < count; m++)
			for (int e = 0; e < n; e++)
				if (extremes)
					element_queue.push_back((e % 3 == 0) ? 16'h8000 :
						(e % 3 == 1) ? 16'h7fff : 16'hffff);
				else
					element_queue.push_back(16'($urandom));
	endtask

	initial begin
		logic [3:0] rsel, csel;
		arst_n = 1'b0; cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
		rows_reg = 4'd8; cols_reg = 4'd8; elem_count = 0;
		mismatch_count = 0; idle_cycles = 0; timed_out = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: small sizes, extreme values, then full size
		write_size(gram_pkg::REG_ROWS, 4'd1); write_size(gram_pkg::REG_COLS, 4'd1);
		element_queue.push_back(16'h8000);
		element_queue.push_back(16'h7fff);
		element_queue.push_back(16'h0000);
		drain();
		write_size(gram_pkg::REG_ROWS, 4'd2); write_size(gram_pkg::REG_COLS, 4'd3);
		queue_matrices(1, 1'b1);
		drain();
		write_size(gram_pkg::REG_ROWS, 4'd8); write_size(gram_pkg::REG_COLS, 4'd8);
		queue_matrices(1, 1'b1);
		drain();
		// out-of-range registers: zero acts as one, above eight as eight
		write_size(gram_pkg::REG_ROWS, 4'd0); write_size(gram_pkg::REG_COLS, 4'd15);
		queue_matrices(1, 1'b0);
		drain();

		// random sizes, mostly small
		for (int ph = 0; ph < 10 && !timed_out; ph++) begin
			rsel = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(1, 4));
			csel = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(1, 5));
			write_size(gram_pkg::REG_ROWS, rsel); write_size(gram_pkg::REG_COLS, csel);
			queue_matrices((clamp8(rsel) * clamp8(csel) > 20) ? 1 : 3, 1'b0);
			drain();
		end

		if (timed_out || entry_queue.size() > 0) begin
			$display("[FAIL] regression broken");
		end else if (mismatch_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end
endmodule

>>> sim.f
design/gram_pkg.sv
design/gram_cell.sv
design/gram_matrix_a_times_a_transpose.sv
tb/sv/tb.sv
